// ===== src/tbw_pkg.sv =====
`default_nettype none

package tbw_pkg;

   // Field and register widths
   localparam int NORMAL_W = 16;
   localparam int CFG_W = 16;
   localparam int WEIGHT_W = 17;
   localparam int NUM_LANES = 3;

   // Log stage: magnitude, top-bit index, Q.16 log value
   localparam int MAG_W = 16;
   localparam int LZ_W = 4;
   localparam int FRAC_W = 16;
   localparam int MANT_POINT = 14;
   localparam int LOG_W = LZ_W + 1 + FRAC_W;

   // Product of log and Q4.12 exponent
   localparam int EXP_FRAC_LSB = 12;
   localparam int EXP_INT_LSB = FRAC_W + EXP_FRAC_LSB;
   localparam int PROD_W = LOG_W + CFG_W + 1;
   localparam int K_W = PROD_W - EXP_INT_LSB;

   // Exp2 stage and power in Q.24
   localparam int MANT_W = FRAC_W + 1;
   localparam int POW_FRAC_W = 24;
   localparam int SHIFT_W = K_W + 1;
   localparam int SHL_W = 6;
   localparam int SHR_W = 5;
   localparam int POW_W = 56;
   localparam int SUM_W = POW_W + 2;

   // Normalizing divider
   localparam int NUM_W = 64;
   localparam int QUO_W = WEIGHT_W;
   localparam int CMP_W = SUM_W + QUO_W;

   // Pipeline depth
   localparam int LANE_STAGES = 3;
   localparam int DIV_STAGES = 3 + QUO_W;
   localparam int SUM_TAPS = DIV_STAGES - 1;
   localparam int PIPE_STAGES = LANE_STAGES + DIV_STAGES;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h1_0000;
   localparam logic [POW_W-1:0] POW_ONE = 56'h100_0000;
   localparam logic [CFG_W-1:0] BLEND_EXPONENT_RESET = 16'd4096;
   localparam logic [CFG_W-1:0] WEIGHT_FLOOR_RESET = 16'd7;

   localparam int CSR_IDX_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLEND_EXPONENT = 1'b0,
      CSR_WEIGHT_FLOOR   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic empty;
      logic sum_zero;
   } tag_type;

endpackage

`default_nettype wire

// ===== src/tbw_if.sv =====
`default_nettype none

interface tbw_req_if;
   import tbw_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [NORMAL_W-1:0] normal_x;
   logic signed [NORMAL_W-1:0] normal_y;
   logic signed [NORMAL_W-1:0] normal_z;

   modport source (output valid, output normal_x, output normal_y, output normal_z,
                   input ready);
   modport sink (input valid, input normal_x, input normal_y, input normal_z,
                 output ready);
endinterface

interface tbw_rsp_if;
   import tbw_pkg::*;

   logic                valid;
   logic                ready;
   logic [WEIGHT_W-1:0] weight_x;
   logic [WEIGHT_W-1:0] weight_y;
   logic [WEIGHT_W-1:0] weight_z;
   logic                empty_normal;

   modport source (output valid, output weight_x, output weight_y, output weight_z,
                   output empty_normal, input ready);
   modport sink (input valid, input weight_x, input weight_y, input weight_z,
                 input empty_normal, output ready);
endinterface

`default_nettype wire

// ===== src/triplanar_blend_weights.sv =====
// Triplanar blend weights.
// Request channel req_ch carries one surface normal (normal_x/y/z, signed Q2.14);
// response channel rsp_ch returns weight_x/y/z (Q1.16, 65536 is one) and
// empty_normal. Both use valid/ready; a transfer happens when both are high.
// Configuration: csr_write_en with csr_index and csr_wdata writes
// blend_exponent (index 0, Q4.12) or weight_floor (index 1). Write only while
// no request is in flight.
// Throughput: one request per cycle, sustained while rsp_ch.ready is high. The
// depth comes from three lane stages (log2, multiply, exp2), a sum stage, a
// numerator stage, a range check and one stage per quotient bit of the
// 17-bit restoring divider in each lane, then the output register.
// Stalls: each stage advances when it is empty or the stage after it
// advances, so bubbles collapse and requests keep entering while a response
// waits at the output; req_ch.ready drops only when every stage is full and
// rsp_ch is stalled. Reset (synchronous) empties the pipeline and loads
// blend_exponent = 1.0 and weight_floor = 7.
`default_nettype none

module triplanar_blend_weights (
   input  logic                           clock,
   input  logic                           reset,
   tbw_req_if.sink                        req_ch,
   tbw_rsp_if.source                      rsp_ch,
   input  logic                           csr_write_en,
   input  logic [tbw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tbw_pkg::CFG_W-1:0]      csr_wdata
);
   import tbw_pkg::*;

   logic [CFG_W-1:0]      blend_exponent_ff, blend_exponent_in;
   logic [CFG_W-1:0]      weight_floor_ff, weight_floor_in;

   logic [PIPE_STAGES:0]   stage_en;
   logic [PIPE_STAGES-1:0] valid_ff, valid_in;
   tag_type               tag_ff [PIPE_STAGES];
   tag_type               tag_in [PIPE_STAGES];

   logic [NORMAL_W-1:0]   lane_comp [NUM_LANES];
   logic [POW_W-1:0]      lane_pow [NUM_LANES];
   logic [WEIGHT_W-1:0]   lane_weight [NUM_LANES];

   logic [SUM_W-1:0]      sum_ff [SUM_TAPS];
   logic [SUM_W-1:0]      sum_in;

   logic                  rsp_valid_ff;
   logic [WEIGHT_W-1:0]   weight_ff [NUM_LANES];
   logic [WEIGHT_W-1:0]   weight_in [NUM_LANES];
   logic                  empty_ff, empty_in;

   // Register writes; the index is decoded in full
   always_comb begin
      blend_exponent_in = blend_exponent_ff;
      weight_floor_in = weight_floor_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_BLEND_EXPONENT: blend_exponent_in = csr_wdata;
            CSR_WEIGHT_FLOOR:   weight_floor_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_exponent_ff <= BLEND_EXPONENT_RESET;
         weight_floor_ff <= WEIGHT_FLOOR_RESET;
      end else begin
         blend_exponent_ff <= blend_exponent_in;
         weight_floor_ff <= weight_floor_in;
      end
   end

   // Advance a stage when it is empty or everything after it can move;
   // the output register moves when it is empty or the response is taken.
   assign stage_en[PIPE_STAGES] = !rsp_valid_ff || rsp_ch.ready;
   for (genvar s = 0; s < PIPE_STAGES; s++) begin : g_en
      assign stage_en[s] = stage_en[PIPE_STAGES] || !(&valid_ff[PIPE_STAGES-1:s]);
   end

   assign req_ch.ready = stage_en[0];

   // Valid bits and per-request flags travel alongside the lanes
   always_comb begin
      valid_in[0] = req_ch.valid;
      tag_in[0] = '{empty: (req_ch.normal_x == '0) && (req_ch.normal_y == '0)
                           && (req_ch.normal_z == '0),
                    sum_zero: 1'b0};
      for (int s = 1; s < PIPE_STAGES; s++) begin
         valid_in[s] = valid_ff[s-1];
         tag_in[s] = tag_ff[s-1];
      end
      // Flag a sum of zero where the sum is formed
      tag_in[LANE_STAGES].sum_zero = (lane_pow[0] | lane_pow[1] | lane_pow[2]) == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < PIPE_STAGES; s++) begin
            if (stage_en[s]) valid_ff[s] <= valid_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < PIPE_STAGES; s++) begin
         if (stage_en[s]) tag_ff[s] <= tag_in[s];
      end
   end

   assign lane_comp[0] = req_ch.normal_x;
   assign lane_comp[1] = req_ch.normal_y;
   assign lane_comp[2] = req_ch.normal_z;

   // One power lane per component
   for (genvar l = 0; l < NUM_LANES; l++) begin : g_power
      tbw_power_lane u_power (
         .clock     (clock),
         .component (lane_comp[l]),
         .exponent  (blend_exponent_ff),
         .stage_en  (stage_en[LANE_STAGES-1:0]),
         .power     (lane_pow[l])
      );
   end

   // Merge: sum the three powers, then hold the sum beside every divider step
   assign sum_in = SUM_W'(lane_pow[0]) + SUM_W'(lane_pow[1]) + SUM_W'(lane_pow[2]);

   always_ff @(posedge clock) begin
      if (stage_en[LANE_STAGES]) sum_ff[0] <= sum_in;
      for (int i = 1; i < SUM_TAPS; i++) begin
         if (stage_en[LANE_STAGES+i]) sum_ff[i] <= sum_ff[i-1];
      end
   end

   // One normalizing divider per component
   for (genvar l = 0; l < NUM_LANES; l++) begin : g_div
      tbw_div_lane u_div (
         .clock    (clock),
         .power    (lane_pow[l]),
         .divisor  (sum_ff),
         .stage_en (stage_en[PIPE_STAGES-1:LANE_STAGES]),
         .weight   (lane_weight[l])
      );
   end

   // Drop weights for an empty normal, a zero sum, or below the floor
   always_comb begin
      empty_in = tag_ff[PIPE_STAGES-1].empty;
      for (int l = 0; l < NUM_LANES; l++) begin
         weight_in[l] = lane_weight[l];
         if (tag_ff[PIPE_STAGES-1].empty || tag_ff[PIPE_STAGES-1].sum_zero
             || lane_weight[l] < WEIGHT_W'(weight_floor_ff)) begin
            weight_in[l] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_en[PIPE_STAGES]) begin
         rsp_valid_ff <= valid_ff[PIPE_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[PIPE_STAGES]) begin
         weight_ff <= weight_in;
         empty_ff <= empty_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.weight_x = weight_ff[0];
   assign rsp_ch.weight_y = weight_ff[1];
   assign rsp_ch.weight_z = weight_ff[2];
   assign rsp_ch.empty_normal = empty_ff;

`ifndef SYNTHESIS
   // Backpressure reaches the input only when the whole pipeline is full
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (&valid_ff) && rsp_ch.valid && !rsp_ch.ready)
      else $error("request stalled with room in the pipeline");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.empty_normal |->
         rsp_ch.weight_x == '0 && rsp_ch.weight_y == '0 && rsp_ch.weight_z == '0)
      else $error("empty normal with nonzero weight");

   a_weight_max: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.weight_x <= WEIGHT_ONE && rsp_ch.weight_y <= WEIGHT_ONE
                       && rsp_ch.weight_z <= WEIGHT_ONE)
      else $error("weight above one");

   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid && valid_ff == '0)
      else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

// ===== src/tbw_power_lane.sv =====
`default_nettype none

module tbw_power_lane (
   input  logic                               clock,
   input  logic [tbw_pkg::NORMAL_W-1:0]       component,
   input  logic [tbw_pkg::CFG_W-1:0]          exponent,
   input  logic [tbw_pkg::LANE_STAGES-1:0]    stage_en,
   output logic [tbw_pkg::POW_W-1:0]          power
);
   import tbw_pkg::*;

   logic [MAG_W-1:0]          mag;
   logic [LZ_W-1:0]           top_bit;
   logic [2*MAG_W-1:0]        norm;
   logic [LZ_W:0]             char_in;
   logic signed [LOG_W-1:0]   log_in, log_ff;
   logic                      zero_in, zero1_ff, zero2_ff;
   logic signed [PROD_W-1:0]  prod_in, prod_ff;
   logic signed [SHIFT_W-1:0] shift_amt;
   logic [SHIFT_W-1:0]        neg_amt;
   logic [MANT_W-1:0]         mant_exp;
   logic [POW_W-1:0]          pow_in, pow_ff;

   // Log2: magnitude, top set bit, normalized mantissa
   always_comb begin
      mag = component[NORMAL_W-1] ? MAG_W'(-component) : component;
      zero_in = (mag == '0);
      top_bit = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (mag[i]) top_bit = LZ_W'(i);
      end
      norm = {mag, FRAC_W'(0)} >> top_bit;
      char_in = (LZ_W+1)'({1'b0, top_bit}) - (LZ_W+1)'(MANT_POINT);
      log_in = {char_in, norm[FRAC_W-1:0]};
   end

   assign prod_in = PROD_W'(log_ff) * PROD_W'($signed({1'b0, exponent}));

   // Exp2: integer part sets the shift, fraction forms the mantissa
   always_comb begin
      shift_amt = {{(SHIFT_W-K_W){prod_ff[PROD_W-1]}}, prod_ff[PROD_W-1:EXP_INT_LSB]}
                  + SHIFT_W'(POW_FRAC_W - FRAC_W);
      neg_amt = -shift_amt;
      mant_exp = {1'b1, prod_ff[EXP_INT_LSB-1:EXP_FRAC_LSB]};
      if (exponent == '0) begin
         pow_in = POW_ONE;
      end else if (zero2_ff) begin
         pow_in = '0;
      end else if (!shift_amt[SHIFT_W-1]) begin
         pow_in = POW_W'(mant_exp) << shift_amt[SHL_W-1:0];
      end else if (neg_amt >= SHIFT_W'(MANT_W)) begin
         pow_in = '0;
      end else begin
         pow_in = POW_W'(mant_exp >> neg_amt[SHR_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         log_ff <= log_in;
         zero1_ff <= zero_in;
      end
      if (stage_en[1]) begin
         prod_ff <= prod_in;
         zero2_ff <= zero1_ff;
      end
      if (stage_en[2]) begin
         pow_ff <= pow_in;
      end
   end

   assign power = pow_ff;

endmodule

`default_nettype wire

// ===== src/tbw_div_lane.sv =====
`default_nettype none

module tbw_div_lane (
   input  logic                             clock,
   input  logic [tbw_pkg::POW_W-1:0]        power,
   input  logic [tbw_pkg::SUM_W-1:0]        divisor [tbw_pkg::SUM_TAPS],
   input  logic [tbw_pkg::DIV_STAGES-1:0]   stage_en,
   output logic [tbw_pkg::WEIGHT_W-1:0]     weight
);
   import tbw_pkg::*;

   logic [POW_W-1:0] pow_ff;
   logic [NUM_W-1:0] num_in, num_ff;
   logic             sat_in;
   logic [NUM_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic             sat_ff [QUO_W+1];

   // Numerator wraps at 64 bits; add half the sum to round to nearest
   assign num_in = {pow_ff[NUM_W-FRAC_W-1:0], FRAC_W'(0)} + NUM_W'(divisor[0] >> 1);
   // Quotient of 2^17 or more saturates
   assign sat_in = CMP_W'(num_ff) >= {divisor[1], QUO_W'(0)};

   always_ff @(posedge clock) begin
      if (stage_en[0]) pow_ff <= power;
      if (stage_en[1]) num_ff <= num_in;
      if (stage_en[2]) begin
         rem_ff[0] <= num_ff;
         sat_ff[0] <= sat_in;
      end
   end

   // One restoring step per stage, most significant quotient bit first
   for (genvar j = 0; j < QUO_W; j++) begin : g_step
      localparam int BIT = QUO_W - 1 - j;
      logic [CMP_W-1:0] trial;
      logic             fits;
      logic [NUM_W-1:0] rem_in;
      logic [QUO_W-1:0] quo_prev;
      logic [QUO_W-1:0] quo_in;

      if (j == 0) begin : g_first
         assign quo_prev = '0;
      end else begin : g_next
         assign quo_prev = quo_ff[j-1];
      end

      always_comb begin
         trial = CMP_W'(divisor[2+j]) << BIT;
         fits = CMP_W'(rem_ff[j]) >= trial;
         rem_in = fits ? rem_ff[j] - trial[NUM_W-1:0] : rem_ff[j];
         quo_in = quo_prev;
         quo_in[BIT] = fits;
      end

      always_ff @(posedge clock) begin
         if (stage_en[3+j]) begin
            quo_ff[j] <= quo_in;
            sat_ff[j+1] <= sat_ff[j];
         end
      end

      if (j < QUO_W - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (stage_en[3+j]) rem_ff[j+1] <= rem_in;
         end
      end
   end

   // Clamp to one
   assign weight = (sat_ff[QUO_W] || quo_ff[QUO_W-1] > WEIGHT_ONE) ? WEIGHT_ONE
                                                                     : quo_ff[QUO_W-1];

endmodule

`default_nettype wire
